@@ src/fdr_pkg.sv @@
// Shared types and constants for the Fresnel dielectric reflectance block.
// Holds the request and result payload structs and the fixed-point widths.
// No dependencies.
package fdr_pkg;

  // Fixed-point formats: cosines Q2.14, reflectance Q1.14, eta Q4.12, inside Q.30.
  localparam int FRAC_BITS = 14;
  localparam int WF        = 30;
  localparam int ETA_FRAC  = 12;
  localparam int ONE       = 1 << FRAC_BITS;

  localparam logic [15:0] ETA_MIN  = 16'd256;
  localparam logic [15:0] ETA_UNIT = 16'(1 << ETA_FRAC);

  // Reciprocal of eta squared: divisor width and number of quotient cells.
  localparam int SC_DW    = 32;
  localparam int SC_CELLS = 40;

  // Square root of a Q.60 value: remainder width, root width, cells.
  localparam int SQ_XW    = 61;
  localparam int SQ_RW    = 62;
  localparam int SQ_CELLS = 31;

  // Squared amplitude ratio unit.
  localparam int RT_AW    = 34;
  localparam int RT_DW    = 33;
  localparam int RT_CELLS = 32;
  localparam int RT_LAT   = RT_CELLS + 4;
  localparam int SQR_W    = 61;

  typedef struct packed {
    logic signed [15:0] cos_incident;
    logic [15:0]        eta_ratio;
  } request_t;

  typedef struct packed {
    logic [14:0]        reflectance;
    logic signed [15:0] cos_transmitted;
    logic               total_reflection;
  } result_t;

endpackage

@@ src/fdr_div_cell.sv @@
// One restoring division step: compare, subtract, shift in one quotient bit.
// Registered; advances when en is high. Uses no package items.
module fdr_div_cell #(
  parameter int DW = 32,
  parameter int QW = 40
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW:0]   x_in,
  input  logic [DW-1:0] d_in,
  input  logic [QW-1:0] q_in,
  output logic [DW:0]   x_out,
  output logic [DW-1:0] d_out,
  output logic [QW-1:0] q_out
);

  logic        ge;
  logic [DW:0] rem;

  // The partial remainder stays below the divisor, so it fits DW bits.
  assign ge  = x_in >= {1'b0, d_in};
  assign rem = ge ? (x_in - {1'b0, d_in}) : x_in;

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= {rem[DW-1:0], 1'b0};
      d_out <= d_in;
      q_out <= {q_in[QW-2:0], ge};
    end
  end

endmodule

@@ src/fdr_sqrt_cell.sv @@
// One digit-by-digit square root step for root bit K, registered.
// Advances when en is high. Uses no package items.
module fdr_sqrt_cell #(
  parameter int K  = 30,
  parameter int XW = 61,
  parameter int RW = 62
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x_in,
  input  logic [RW-1:0] r_in,
  output logic [XW-1:0] x_out,
  output logic [RW-1:0] r_out
);

  localparam logic [RW-1:0] BIT = RW'(1) << (2 * K);

  logic [RW-1:0] trial;
  logic          ge;

  assign trial = r_in + BIT;
  assign ge    = RW'(x_in) >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= ge ? (x_in - trial[XW-1:0]) : x_in;
      r_out <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
    end
  end

endmodule

@@ src/fdr_sq_ratio.sv @@
// Squared rounded ratio |a-b|/(a+b) in Q.30, giving a Q.60 square.
// Depends on fdr_pkg and a chain of fdr_div_cell.
module fdr_sq_ratio (
  input  logic                       clk,
  input  logic                       en,
  input  logic [fdr_pkg::RT_AW-1:0]  a,
  input  logic [fdr_pkg::RT_AW-1:0]  b,
  output logic [fdr_pkg::SQR_W-1:0]  sq
);
  import fdr_pkg::*;

  logic [RT_AW-1:0]  n1;
  logic [RT_AW:0]    d1;
  logic [RT_DW-1:0]  n2;
  logic [RT_DW-1:0]  d2;
  logic [RT_DW:0]    cx [RT_CELLS+1];
  logic [RT_DW-1:0]  cd [RT_CELLS+1];
  logic [RT_CELLS-1:0] cq [RT_CELLS+1];
  logic [WF:0]       q3;

  always_ff @(posedge clk) begin
    if (en) begin
      n1 <= (a >= b) ? (a - b) : (b - a);
      d1 <= (RT_AW + 1)'(a) + (RT_AW + 1)'(b);
    end
  end

  // Halve both terms until the denominator drops below 2^33.
  always_ff @(posedge clk) begin
    if (en) begin
      if (d1[RT_AW]) begin
        n2 <= RT_DW'(n1 >> 2);
        d2 <= RT_DW'(d1 >> 2);
      end else if (d1[RT_AW-1]) begin
        n2 <= RT_DW'(n1 >> 1);
        d2 <= RT_DW'(d1 >> 1);
      end else begin
        n2 <= n1[RT_DW-1:0];
        d2 <= d1[RT_DW-1:0];
      end
    end
  end

  assign cx[0] = {1'b0, n2};
  assign cd[0] = d2;
  assign cq[0] = '0;

  for (genvar i = 0; i < RT_CELLS; i++) begin : g_div
    fdr_div_cell #(.DW(RT_DW), .QW(RT_CELLS)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (cx[i]),
      .d_in  (cd[i]),
      .q_in  (cq[i]),
      .x_out (cx[i+1]),
      .d_out (cd[i+1]),
      .q_out (cq[i+1])
    );
  end

  // The chain yields floor(n * 2^31 / d); halving with a carry rounds to Q.30.
  always_ff @(posedge clk) begin
    if (en) begin
      q3 <= (WF + 1)'(((RT_CELLS + 1)'(cq[RT_CELLS]) + 1'b1) >> 1);
      sq <= SQR_W'((2 * WF + 2)'(q3) * (2 * WF + 2)'(q3));
    end
  end

endmodule

@@ src/fresnel_dielectric_reflectance.sv @@
// Top level of the Fresnel dielectric reflectance block.
// Depends on fdr_pkg, fdr_div_cell, fdr_sqrt_cell and fdr_sq_ratio.

// Each request carries a signed Q2.14 incident cosine and a Q4.12 relative
// index of refraction; each result carries the unpolarized Q1.14 reflectance,
// the signed transmitted cosine and a total internal reflection flag. The
// block takes one request per clock while request_stall is low and returns
// results in request order. The pipeline is built on three chains of one-bit
// cells: 40 cells form 1/eta^2, 31 cells form the transmitted cosine by
// square root, and 32 cells in each of two ratio units form the amplitude
// ratios. A two-entry output buffer holds results while the result side
// stalls; the request side is stalled only when that buffer is full, and
// then the whole pipeline holds. Eta below 256 is raised to 256 and cosines
// beyond one are clipped to one before any work is done.
module fresnel_dielectric_reflectance (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_stall,
  input  fdr_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_stall,
  output fdr_pkg::result_t  result
);
  import fdr_pkg::*;

  // Pipeline positions: input stage, reciprocal chain, three multiply and
  // compare stages, square root chain, two stages, then the ratio units.
  localparam int DEPTH = 1 + SC_CELLS + 3 + SQ_CELLS + 2 + RT_LAT;

  localparam logic signed [15:0] C_ONE  = 16'(ONE);
  localparam logic [WF:0]        ONE_WF = (WF + 1)'(1) << WF;
  localparam logic [SC_DW:0]     SC_X0  =
    (SC_DW + 1)'(1) << (WF + 2 * ETA_FRAC + 1 - (SC_CELLS - 1));

  // Sideband that travels beside the reciprocal chain.
  typedef struct packed {
    logic               pos;
    logic               eta_one;
    logic signed [15:0] negc;
    logic [14:0]        cabs;
    logic [15:0]        eta;
    logic [WF:0]        s2;
    logic [33:0]        ec;
  } side_a_t;

  // Sideband that travels beside the square root chain.
  typedef struct packed {
    logic               pos;
    logic               eta_one;
    logic               tir;
    logic signed [15:0] negc;
    logic [14:0]        cabs;
    logic [15:0]        eta;
    logic [33:0]        ec;
  } side_b_t;

  // Sideband that travels beside the ratio units.
  typedef struct packed {
    logic               pos;
    logic               eta_one;
    logic               tir;
    logic signed [15:0] negc;
    logic [WF:0]        ct;
  } side_c_t;

  logic             en;
  logic             accept;
  logic             push;
  logic [DEPTH-1:0] vld;
  logic             skid_valid;
  result_t          skid;
  result_t          res_new;

  // The pipeline moves as one; it holds only while the skid entry is full.
  assign en            = !skid_valid;
  assign request_stall = skid_valid;
  assign accept        = request_valid && en;
  assign push          = en && vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], accept};
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: clip the operands, form eta squared, the squared sine
  // (one minus cos squared) and eta times the incident cosine.
  // ---------------------------------------------------------------------
  logic signed [15:0] c_sat;
  logic [14:0]        cabs_w;
  logic [15:0]        eta_c;
  logic [29:0]        csq;
  logic [29:0]        ecp;
  side_a_t            a_side;
  logic [SC_DW-1:0]   a_e;

  always_comb begin
    if (request.cos_incident > C_ONE) begin
      c_sat = C_ONE;
    end else if (request.cos_incident < -C_ONE) begin
      c_sat = -C_ONE;
    end else begin
      c_sat = request.cos_incident;
    end
    cabs_w = c_sat[15] ? 15'(-c_sat) : 15'(c_sat);
    eta_c  = (request.eta_ratio < ETA_MIN) ? ETA_MIN : request.eta_ratio;
    csq    = 30'(cabs_w) * 30'(cabs_w);
    ecp    = 30'(31'(eta_c) * 31'(cabs_w));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.pos     <= c_sat > 16'sd0;
      a_side.eta_one <= eta_c == ETA_UNIT;
      a_side.negc    <= -c_sat;
      a_side.cabs    <= cabs_w;
      a_side.eta     <= eta_c;
      a_side.s2      <= ONE_WF - (WF + 1)'({csq, 2'b00});
      a_side.ec      <= {ecp, 4'b0000};
      a_e            <= SC_DW'(eta_c) * SC_DW'(eta_c);
    end
  end

  // ---------------------------------------------------------------------
  // Reciprocal chain: floor(2^55 / eta^2), one quotient bit per cell.
  // ---------------------------------------------------------------------
  logic [SC_DW:0]    sc_x [SC_CELLS+1];
  logic [SC_DW-1:0]  sc_d [SC_CELLS+1];
  logic [SC_CELLS-1:0] sc_q [SC_CELLS+1];
  side_a_t           sl1  [SC_CELLS];

  assign sc_x[0] = SC_X0;
  assign sc_d[0] = a_e;
  assign sc_q[0] = '0;

  for (genvar i = 0; i < SC_CELLS; i++) begin : g_recip
    fdr_div_cell #(.DW(SC_DW), .QW(SC_CELLS)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (sc_x[i]),
      .d_in  (sc_d[i]),
      .q_in  (sc_q[i]),
      .x_out (sc_x[i+1]),
      .d_out (sc_d[i+1]),
      .q_out (sc_q[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl1[0] <= a_side;
      for (int i = 1; i < SC_CELLS; i++) begin
        sl1[i] <= sl1[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Snell scale, then sin^2 of the transmitted angle as s2 * scale, which
  // is split into two partial products on the high and low scale bits.
  // ---------------------------------------------------------------------
  side_a_t         c_side;
  logic [38:0]     c_sc2;
  side_a_t         d_side;
  logic [39:0]     d_hi;
  logic [60:0]     d_lo;
  logic [40:0]     t_w;
  side_b_t         e_side;
  logic [WF:0]     e_ct2;

  always_ff @(posedge clk) begin
    if (en) begin
      c_side <= sl1[SC_CELLS-1];
      // A positive cosine scales by 1/eta^2, otherwise by eta^2.
      if (sl1[SC_CELLS-1].pos) begin
        c_sc2 <= 39'(((SC_CELLS + 1)'(sc_q[SC_CELLS]) + 1'b1) >> 1);
      end else begin
        c_sc2 <= 39'({sc_d[SC_CELLS], 6'b000000});
      end
      d_side <= c_side;
      d_hi   <= 40'(c_side.s2) * 40'(c_sc2[38:WF]);
      d_lo   <= 61'(c_side.s2) * 61'(c_sc2[WF-1:0]);
    end
  end

  assign t_w = 41'(d_hi) + 41'((62'(d_lo) + (62'(1) << (WF - 1))) >> WF);

  always_ff @(posedge clk) begin
    if (en) begin
      e_side.pos     <= d_side.pos;
      e_side.eta_one <= d_side.eta_one;
      e_side.tir     <= t_w >= 41'(ONE_WF);
      e_side.negc    <= d_side.negc;
      e_side.cabs    <= d_side.cabs;
      e_side.eta     <= d_side.eta;
      e_side.ec      <= d_side.ec;
      e_ct2          <= ONE_WF - t_w[WF:0];
    end
  end

  // ---------------------------------------------------------------------
  // Square root chain on cos^2 of the transmitted angle in Q.60.
  // ---------------------------------------------------------------------
  logic [SQ_XW-1:0] sq_x [SQ_CELLS+1];
  logic [SQ_RW-1:0] sq_r [SQ_CELLS+1];
  side_b_t          sl2  [SQ_CELLS];

  assign sq_x[0] = {e_ct2, {WF{1'b0}}};
  assign sq_r[0] = '0;

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sqrt
    fdr_sqrt_cell #(.K(SQ_CELLS - 1 - i), .XW(SQ_XW), .RW(SQ_RW)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (sq_x[i]),
      .r_in  (sq_r[i]),
      .x_out (sq_x[i+1]),
      .r_out (sq_r[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sl2[0] <= e_side;
      for (int i = 1; i < SQ_CELLS; i++) begin
        sl2[i] <= sl2[i-1];
      end
    end
  end

  // Round the root up when the remainder exceeds it, then cap at one.
  logic [WF+1:0] ct_sum;
  side_b_t       g_side;
  logic [WF:0]   g_ct;

  assign ct_sum = sq_r[SQ_CELLS][WF+1:0]
                + (WF + 2)'(SQ_RW'(sq_x[SQ_CELLS]) > sq_r[SQ_CELLS]);

  always_ff @(posedge clk) begin
    if (en) begin
      g_side <= sl2[SQ_CELLS-1];
      g_ct   <= (ct_sum > (WF + 2)'(ONE_WF)) ? ONE_WF : ct_sum[WF:0];
    end
  end

  // ---------------------------------------------------------------------
  // Eta times the transmitted cosine, then the two amplitude ratios.
  // ---------------------------------------------------------------------
  side_c_t          h_side;
  logic [RT_AW-1:0] h_cw;
  logic [RT_AW-1:0] h_ect;
  logic [RT_AW-1:0] h_ec;
  logic [RT_AW-1:0] h_ct;
  logic [SQR_W-1:0] sq_par;
  logic [SQR_W-1:0] sq_perp;
  side_c_t          sl3 [RT_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      h_side.pos     <= g_side.pos;
      h_side.eta_one <= g_side.eta_one;
      h_side.tir     <= g_side.tir;
      h_side.negc    <= g_side.negc;
      h_side.ct      <= g_ct;
      h_cw           <= RT_AW'({g_side.cabs, {(WF - FRAC_BITS){1'b0}}});
      h_ect          <= RT_AW'((47'(g_side.eta) * 47'(g_ct)
                        + (47'(1) << (ETA_FRAC - 1))) >> ETA_FRAC);
      h_ec           <= g_side.ec;
      h_ct           <= RT_AW'(g_ct);
    end
  end

  fdr_sq_ratio u_par (
    .clk (clk),
    .en  (en),
    .a   (h_cw),
    .b   (h_ect),
    .sq  (sq_par)
  );

  fdr_sq_ratio u_perp (
    .clk (clk),
    .en  (en),
    .a   (h_ec),
    .b   (h_ct),
    .sq  (sq_perp)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sl3[0] <= h_side;
      for (int i = 1; i < RT_LAT; i++) begin
        sl3[i] <= sl3[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result: mean of the two squared ratios, rounded cosine, special cases.
  // ---------------------------------------------------------------------
  side_c_t       f_side;
  logic [61:0]   sum_w;
  logic [15:0]   rq_w;
  logic [15:0]   cto_w;
  logic [14:0]   rq;
  logic [14:0]   cto;

  assign f_side = sl3[RT_LAT-1];

  always_comb begin
    sum_w = 62'(sq_par) + 62'(sq_perp);
    rq_w  = 16'((63'(sum_w) + (63'(1) << (2 * WF - FRAC_BITS)))
                >> (2 * WF + 1 - FRAC_BITS));
    cto_w = 16'((32'(f_side.ct) + (32'(1) << (WF - FRAC_BITS - 1)))
                >> (WF - FRAC_BITS));
    rq    = (rq_w > 16'(ONE)) ? 15'(ONE) : rq_w[14:0];
    cto   = (cto_w > 16'(ONE)) ? 15'(ONE) : cto_w[14:0];

    if (f_side.eta_one) begin
      // Matched indices: nothing reflects and the ray passes straight on.
      res_new.reflectance      = '0;
      res_new.cos_transmitted  = f_side.negc;
      res_new.total_reflection = 1'b0;
    end else if (f_side.tir) begin
      res_new.reflectance      = 15'(ONE);
      res_new.cos_transmitted  = '0;
      res_new.total_reflection = 1'b1;
    end else begin
      res_new.reflectance      = rq;
      res_new.cos_transmitted  = f_side.pos ? -16'(cto) : 16'(cto);
      res_new.total_reflection = 1'b0;
    end
  end

  // Two-entry output buffer: the result register plus one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result       <= skid;
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
        if (push) begin
          result <= res_new;
        end
      end
    end else if (push) begin
      skid       <= res_new;
      skid_valid <= 1'b1;
    end
  end

endmodule

@@ dv/tb_fresnel_dielectric_reflectance.sv @@
// Self-checking testbench for the Fresnel dielectric reflectance block.
// Drives directed and random requests and checks every result against a local predictor or a directed expectation.
// Depends on fdr_pkg and fresnel_dielectric_reflectance.
module tb_fresnel_dielectric_reflectance;
  import fdr_pkg::*;

  localparam int NUM_RANDOM  = 1950;
  localparam int DRAIN_WAIT  = 140;
  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_stall;
  request_t request = '0;
  logic     result_valid;
  logic     result_stall = 1'b1;
  result_t  result;

  result_t  pending_results[$];
  int       error_count = 0;
  int       cycle_count = 0;
  bit       calm_window = 1'b0;

  always #5 clk = ~clk;

  fresnel_dielectric_reflectance u_top (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  // Rounded integer square root, bit by bit.
  function automatic logic [63:0] root_round(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (x > r) r = r + 1;
    return r;
  endfunction

  // Squared ratio |a-b|/(a+b) in Q.60, with wide denominators scaled down first.
  function automatic logic [63:0] amp_ratio_sq(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    num = (a >= b) ? a - b : b - a;
    den = a + b;
    while ((den >> 33) != 0) begin
      num = num >> 1;
      den = den >> 1;
    end
    q = (den == 0) ? 64'd0 : ((num << WF) + (den >> 1)) / den;
    if (q > (64'd1 << WF)) q = 64'd1 << WF;
    return q * q;
  endfunction

  // Expected reflectance, transmitted cosine and flag for one request.
  function automatic result_t fresnel_predict(input request_t req);
    result_t     res;
    logic [63:0] onew, eta, cw, c2, s2, sc2, t, ct, ec, ect, sum, rq, cto;
    int          c;
    onew = 64'd1 << WF;
    c    = req.cos_incident;
    eta  = req.eta_ratio;
    if (c > ONE) c = ONE;
    if (c < -ONE) c = -ONE;
    if (eta < ETA_MIN) eta = ETA_MIN;
    res = '0;
    // A matched index passes the ray straight through.
    if (eta == ETA_UNIT) begin
      res.cos_transmitted = 16'(-c);
      return res;
    end
    cw  = 64'(c < 0 ? -c : c) << (WF - FRAC_BITS);
    c2  = (cw * cw + (onew >> 1)) >> WF;
    s2  = onew - c2;
    if (c > 0) sc2 = ((64'd1 << (WF + 2 * ETA_FRAC)) + ((eta * eta) >> 1)) / (eta * eta);
    else       sc2 = (eta * eta) << (WF - 2 * ETA_FRAC);
    t = s2 * (sc2 >> WF) + ((s2 * (sc2 & (onew - 1)) + (onew >> 1)) >> WF);
    if (t >= onew) begin
      res.reflectance      = 15'(ONE);
      res.total_reflection = 1'b1;
      return res;
    end
    ct = root_round((onew - t) << WF);
    if (ct > onew) ct = onew;
    ec  = (eta * cw + (64'd1 << (ETA_FRAC - 1))) >> ETA_FRAC;
    ect = (eta * ct + (64'd1 << (ETA_FRAC - 1))) >> ETA_FRAC;
    sum = amp_ratio_sq(cw, ect) + amp_ratio_sq(ec, ct);
    rq  = (sum + (64'd1 << (2 * WF - FRAC_BITS))) >> (2 * WF + 1 - FRAC_BITS);
    if (rq > ONE) rq = ONE;
    cto = (ct + (64'd1 << (WF - FRAC_BITS - 1))) >> (WF - FRAC_BITS);
    if (cto > ONE) cto = ONE;
    res.reflectance     = 15'(rq);
    res.cos_transmitted = (c > 0) ? -16'(cto) : 16'(cto);
    return res;
  endfunction

  // Directed rows: a request, and an expected result where it is obvious.
  typedef struct {
    request_t req;
    bit       known;
    result_t  res;
  } directed_row_t;

  directed_row_t directed_rows[] = '{
    // Matched index: zero reflectance, cosine simply negated.
    '{'{16'sd16384, ETA_UNIT}, 1, '{15'd0, -16'sd16384, 1'b0}},
    '{'{-16'sd16384, ETA_UNIT}, 1, '{15'd0, 16'sd16384, 1'b0}},
    '{'{16'sd0, ETA_UNIT}, 1, '{15'd0, 16'sd0, 1'b0}},
    // Cosines beyond one are clipped before the pass-through.
    '{'{16'sh7FFF, ETA_UNIT}, 1, '{15'd0, -16'sd16384, 1'b0}},
    '{'{16'sh8000, ETA_UNIT}, 1, '{15'd0, 16'sd16384, 1'b0}},
    // Grazing ray from the dense side reflects totally.
    '{'{16'sd0, 16'd8192}, 1, '{15'd16384, 16'sd0, 1'b1}},
    '{'{16'sd0, 16'hFFFF}, 1, '{15'd16384, 16'sd0, 1'b1}},
    '{'{-16'sd1, 16'd8192}, 1, '{15'd16384, 16'sd0, 1'b1}},
    '{'{-16'sd100, 16'hFFFF}, 1, '{15'd16384, 16'sd0, 1'b1}},
    // The rest go through the predictor.
    '{'{16'sd16384, 16'd6144}, 0, '0},
    '{'{-16'sd16384, 16'd6144}, 0, '0},
    '{'{16'sd16384, 16'hFFFF}, 0, '0},
    '{'{-16'sd16384, 16'hFFFF}, 0, '0},
    '{'{16'sd16384, 16'd256}, 0, '0},
    '{'{-16'sd16384, 16'd256}, 0, '0},
    '{'{16'sd0, 16'd256}, 0, '0},
    '{'{16'sd0, 16'd0}, 0, '0},
    '{'{16'sd8000, 16'd255}, 0, '0},
    '{'{16'sd200, 16'd2048}, 0, '0},
    '{'{16'sd11585, 16'd6144}, 0, '0},
    '{'{-16'sd11585, 16'd6144}, 0, '0},
    '{'{16'sh7FFF, 16'd4095}, 0, '0},
    '{'{16'sh8000, 16'd4097}, 0, '0},
    '{'{-16'sd1, 16'd5000}, 0, '0}
  };

  // Send one request and hold it until the block takes it. The stall is
  // registered, so its value at the falling edge is the one the next
  // rising edge sees.
  task automatic send_request(input request_t req, input bit known, input result_t res);
    bit taken;
    while (!calm_window && $urandom_range(99) < 27) begin
      request_valid <= 1'b0;
      @(posedge clk);
    end
    request_valid <= 1'b1;
    request       <= req;
    do begin
      @(negedge clk);
      taken = !request_stall;
      @(posedge clk);
    end while (!taken);
    pending_results.push_back(known ? res : fresnel_predict(req));
  endtask

  // Random request: mostly in-range cosines and common indices, with some
  // matched indices, tiny indices and raw bit patterns mixed in.
  function automatic request_t random_request();
    request_t req;
    int       pick;
    pick = $urandom_range(99);
    req.cos_incident = (pick < 85) ? 16'($urandom_range(32768) - 16384) : 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 60)      req.eta_ratio = 16'($urandom_range(12288, 2048));
    else if (pick < 70) req.eta_ratio = ETA_UNIT;
    else if (pick < 78) req.eta_ratio = 16'($urandom_range(300));
    else                req.eta_ratio = 16'($urandom);
    return req;
  endfunction

  // The result side stalls at random, except in a calm window.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b1;
    end else begin
      result_stall <= !calm_window && ($urandom_range(99) < 27);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.reflectance !== want.reflectance) begin
          $display("%0t: reflectance expected %0d actual %0d",
                   $time, want.reflectance, result.reflectance);
          error_count++;
        end
        if (result.cos_transmitted !== want.cos_transmitted) begin
          $display("%0t: cos_transmitted expected %0d actual %0d",
                   $time, want.cos_transmitted, result.cos_transmitted);
          error_count++;
        end
        if (result.total_reflection !== want.total_reflection) begin
          $display("%0t: total_reflection expected %0b actual %0b",
                   $time, want.total_reflection, result.total_reflection);
          error_count++;
        end
      end
    end
  end

  // Guard against a hung pipeline.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].res);
    end
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // A stretch in the middle runs at full rate on both sides.
      calm_window = (n >= 800 && n < 1100);
      send_request(random_request(), 1'b0, '0);
    end
    calm_window = 1'b0;
    request_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
